>>> rtl/pabg_pkg.sv
`default_nettype none

package pabg_pkg;

  // Field widths of the input and result words.
  localparam int ADDR_W = 8;
  localparam int SLOT_W = 4;
  localparam int VAL_W  = 11;

  // Default sizing of the gatherer.
  localparam int NUM_ADDRESSES_DEF = 256;
  localparam int BLOCK_LENGTH_DEF  = 15;
  localparam int VALUE_WIDTH_DEF   = 11;

  // Depth of the command queue between the front and back ends.
  localparam int QUEUE_DEPTH = 4;

  // Commands passed from the front end to the back end.
  localparam int OP_W = 2;
  typedef enum logic [OP_W-1:0] {
    OP_STORE      = 2'd0,
    OP_STORE_EMIT = 2'd1,
    OP_FLUSH      = 2'd2
  } op_t;

endpackage

`default_nettype wire

>>> rtl/pabg_if.sv
`default_nettype none

// Input channel: one word is a store or flush command.
interface pabg_in_if import pabg_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     command;
  logic [ADDR_W-1:0]        address;
  logic signed [VAL_W-1:0]  data_value;

  modport source (output valid, command, address, data_value, input ready);
  modport sink   (input valid, command, address, data_value, output ready);
endinterface

// Result channel: one word is one slot of an emitted block.
interface pabg_out_if import pabg_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [ADDR_W-1:0]        block_address;
  logic [SLOT_W-1:0]        slot_index;
  logic signed [VAL_W-1:0]  slot_value;
  logic                     last_of_block;

  modport source (output valid, block_address, slot_index, slot_value, last_of_block,
                  input ready);
  modport sink   (input valid, block_address, slot_index, slot_value, last_of_block,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/per_address_block_gatherer_unit.sv
// Per-address block gatherer. Each input word either stores a value into the
// next free slot of its address or flushes that address. When a store fills
// the last of BLOCK_LENGTH slots, or a flush finds a partly filled block, the
// block goes out as BLOCK_LENGTH result words in slot order, the last one
// marked, with never-filled slots as zero; the address then starts empty.
// Addresses at or above NUM_ADDRESSES are ignored, as are flushes of empty
// addresses. After reset the block runs a clearing pass over the fill count
// memory, during which no input word is taken. The front end takes one input
// word at a time: it accepts it and reads its fill count, then updates the
// count and queues a command, waiting while the queue is full. The back end
// executes a store as it pops it and emits a block at one result word per
// cycle while the result side takes them, paced by the single read port of
// the block store. A four-entry command queue separates the two, so input
// words keep flowing while a block is emitted or the result side stalls.
`default_nettype none

module per_address_block_gatherer_unit import pabg_pkg::*; #(
  parameter int NUM_ADDRESSES = NUM_ADDRESSES_DEF,
  parameter int BLOCK_LENGTH  = BLOCK_LENGTH_DEF,
  parameter int VALUE_WIDTH   = VALUE_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  pabg_in_if.sink    in_chan,
  pabg_out_if.source out_chan
);

  localparam int AW = $clog2(NUM_ADDRESSES);
  localparam int SW = $clog2(BLOCK_LENGTH);
  localparam int QW = OP_W + AW + SW + VALUE_WIDTH;

  logic                   q_push;
  logic                   q_pop;
  logic                   q_full;
  logic                   q_empty;
  op_t                    f_op;
  logic [AW-1:0]          f_addr;
  logic [SW-1:0]          f_slot;
  logic [VALUE_WIDTH-1:0] f_value;
  logic [QW-1:0]          q_wdata;
  logic [QW-1:0]          q_rdata;
  op_t                    b_op;
  logic [AW-1:0]          b_addr;
  logic [SW-1:0]          b_slot;
  logic [VALUE_WIDTH-1:0] b_value;

  // Front end: accept and classify input words.
  pabg_front #(
    .NUM_ADDRESSES (NUM_ADDRESSES),
    .BLOCK_LENGTH  (BLOCK_LENGTH),
    .VALUE_WIDTH   (VALUE_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_push  (q_push),
    .q_full  (q_full),
    .q_op    (f_op),
    .q_addr  (f_addr),
    .q_slot  (f_slot),
    .q_value (f_value)
  );

  // Command queue between the two ends.
  assign q_wdata = {f_op, f_addr, f_slot, f_value};

  pabg_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign b_op    = op_t'(q_rdata[QW-1 -: OP_W]);
  assign b_addr  = q_rdata[SW+VALUE_WIDTH +: AW];
  assign b_slot  = q_rdata[VALUE_WIDTH +: SW];
  assign b_value = q_rdata[VALUE_WIDTH-1:0];

  // Back end: block store and result emission.
  pabg_back #(
    .NUM_ADDRESSES (NUM_ADDRESSES),
    .BLOCK_LENGTH  (BLOCK_LENGTH),
    .VALUE_WIDTH   (VALUE_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .q_op     (b_op),
    .q_addr   (b_addr),
    .q_slot   (b_slot),
    .q_value  (b_value),
    .out_chan (out_chan)
  );

  // The front end never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full))
    else $error("command queue overflow");

  // The back end never pops an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_pop && q_empty))
    else $error("command queue underflow");

  // The marked word of a block is always its final slot.
  a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.last_of_block)
      |-> (out_chan.slot_index == SLOT_W'(BLOCK_LENGTH - 1)))
    else $error("last_of_block on a slot other than the final one");

  // Slots follow each other within a block.
  a_slot_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.ready && !out_chan.last_of_block)
      |=> (out_chan.valid
           |-> (out_chan.slot_index == $past(out_chan.slot_index) + SLOT_W'(1))))
    else $error("result slots out of order");

endmodule

`default_nettype wire

>>> rtl/pabg_front.sv
`default_nettype none

module pabg_front import pabg_pkg::*; #(
  parameter int NUM_ADDRESSES = NUM_ADDRESSES_DEF,
  parameter int BLOCK_LENGTH  = BLOCK_LENGTH_DEF,
  parameter int VALUE_WIDTH   = VALUE_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  pabg_in_if.sink                          in_chan,
  output logic                             q_push,
  input  logic                             q_full,
  output op_t                              q_op,
  output logic [$clog2(NUM_ADDRESSES)-1:0] q_addr,
  output logic [$clog2(BLOCK_LENGTH)-1:0]  q_slot,
  output logic [VALUE_WIDTH-1:0]           q_value
);

  localparam int AW = $clog2(NUM_ADDRESSES);
  localparam int SW = $clog2(BLOCK_LENGTH);

  typedef enum logic [2:0] {
    F_CLEAR  = 3'b001,
    F_IDLE   = 3'b010,
    F_DECIDE = 3'b100
  } fstate_t;

  fstate_t state_r, state_nxt;
  logic [AW-1:0] clr_idx_r, clr_idx_nxt;

  // Captured input word and the fill count read for its address.
  logic                   item_cmd_r;
  logic [ADDR_W-1:0]      item_addr_r;
  logic [VALUE_WIDTH-1:0] item_val_r;
  logic [SW-1:0]          cnt_rd_r;

  // Fill count memory: one count per address.
  logic [SW-1:0] cnt_mem [NUM_ADDRESSES];
  logic          cnt_we;
  logic [AW-1:0] cnt_waddr;
  logic [SW-1:0] cnt_wdata;

  logic          in_fire;
  logic          in_ready;
  logic          in_range;
  logic          last_slot;
  logic          need_push;
  logic [AW-1:0] item_idx;

  assign in_fire       = (state_r == F_IDLE) && in_chan.valid;
  assign in_chan.ready = in_ready;

  // Classification of the captured word.
  assign item_idx  = AW'(item_addr_r);
  assign in_range  = 32'(item_addr_r) < 32'(NUM_ADDRESSES);
  assign last_slot = (cnt_rd_r == SW'(BLOCK_LENGTH - 1));
  assign need_push = in_range && (!item_cmd_r || (cnt_rd_r != '0));

  // Command handed to the back end.
  assign q_op    = item_cmd_r ? OP_FLUSH : (last_slot ? OP_STORE_EMIT : OP_STORE);
  assign q_addr  = item_idx;
  assign q_slot  = cnt_rd_r;
  assign q_value = item_val_r;

  // Sequencer: clearing pass after reset, then accept and decide.
  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    cnt_we      = 1'b0;
    cnt_waddr   = item_idx;
    cnt_wdata   = '0;
    q_push      = 1'b0;
    in_ready    = 1'b0;
    unique case (state_r)
      F_CLEAR: begin
        cnt_we      = 1'b1;
        cnt_waddr   = clr_idx_r;
        clr_idx_nxt = clr_idx_r + AW'(1);
        if (clr_idx_r == AW'(NUM_ADDRESSES - 1)) begin
          state_nxt = F_IDLE;
        end
      end
      F_IDLE: begin
        in_ready = 1'b1;
        if (in_chan.valid) begin
          state_nxt = F_DECIDE;
        end
      end
      F_DECIDE: begin
        if (!(need_push && q_full)) begin
          state_nxt = F_IDLE;
          if (need_push) begin
            q_push    = 1'b1;
            cnt_we    = 1'b1;
            cnt_wdata = (item_cmd_r || last_slot) ? '0 : (cnt_rd_r + SW'(1));
          end
        end
      end
      default: begin
        state_nxt = F_CLEAR;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= F_CLEAR;
      clr_idx_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
    end
  end

  // Capture of the accepted word.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_cmd_r  <= in_chan.command;
      item_addr_r <= in_chan.address;
      item_val_r  <= VALUE_WIDTH'(in_chan.data_value);
    end
  end

  // Fill count memory with a registered read.
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (in_fire) begin
      cnt_rd_r <= cnt_mem[AW'(in_chan.address)];
    end
  end

endmodule

`default_nettype wire

>>> rtl/pabg_fifo.sv
`default_nettype none

module pabg_fifo import pabg_pkg::*; #(
  parameter int WIDTH = OP_W,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign rdata = slots_r[rd_ptr_r];

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

>>> rtl/pabg_back.sv
`default_nettype none

module pabg_back import pabg_pkg::*; #(
  parameter int NUM_ADDRESSES = NUM_ADDRESSES_DEF,
  parameter int BLOCK_LENGTH  = BLOCK_LENGTH_DEF,
  parameter int VALUE_WIDTH   = VALUE_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_empty,
  output logic                             q_pop,
  input  op_t                              q_op,
  input  logic [$clog2(NUM_ADDRESSES)-1:0] q_addr,
  input  logic [$clog2(BLOCK_LENGTH)-1:0]  q_slot,
  input  logic [VALUE_WIDTH-1:0]           q_value,
  pabg_out_if.source                       out_chan
);

  localparam int AW    = $clog2(NUM_ADDRESSES);
  localparam int SW    = $clog2(BLOCK_LENGTH);
  localparam int DEPTH = NUM_ADDRESSES * BLOCK_LENGTH;
  localparam int MW    = $clog2(DEPTH);

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_EMIT = 2'b10
  } bstate_t;

  bstate_t state_r, state_nxt;

  // Block being emitted.
  logic [AW-1:0] emit_addr_r, emit_addr_nxt;
  logic [MW-1:0] base_r, base_nxt;
  logic [SW-1:0] slot_r, slot_nxt;
  logic [SW-1:0] lim_r, lim_nxt;
  logic          all_r, all_nxt;

  // Read stage and output register.
  logic                   p1_valid_r;
  logic [AW-1:0]          p1_addr_r;
  logic [SW-1:0]          p1_slot_r;
  logic                   p1_filled_r;
  logic                   p1_last_r;
  logic [VALUE_WIDTH-1:0] rd_data_r;

  logic                   out_valid_r;
  logic [ADDR_W-1:0]      out_addr_r;
  logic [SLOT_W-1:0]      out_slot_r;
  logic signed [VAL_W-1:0] out_value_r;
  logic                   out_last_r;

  // Block store: one row of slots per address.
  logic [VALUE_WIDTH-1:0] store_mem [DEPTH];

  logic                          wr_en;
  logic [MW-1:0]                 wr_idx;
  logic [MW-1:0]                 q_base;
  logic [MW-1:0]                 rd_idx;
  logic                          issue;
  logic                          out_free;
  logic                          p1_move;
  logic                          p1_free;
  logic signed [VALUE_WIDTH-1:0] rd_sval;

  assign q_base   = MW'(q_addr) * MW'(BLOCK_LENGTH);
  assign wr_idx   = q_base + MW'(q_slot);
  assign rd_idx   = base_r + MW'(slot_r);
  assign out_free = !out_valid_r || out_chan.ready;
  assign p1_move  = p1_valid_r && out_free;
  assign p1_free  = !p1_valid_r || p1_move;
  assign issue    = (state_r == B_EMIT) && p1_free;
  assign rd_sval  = rd_data_r;

  // Command execution: stores write a slot of the row, emits walk its slots.
  always_comb begin
    state_nxt     = state_r;
    emit_addr_nxt = emit_addr_r;
    base_nxt      = base_r;
    slot_nxt      = slot_r;
    lim_nxt       = lim_r;
    all_nxt       = all_r;
    q_pop         = 1'b0;
    wr_en         = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop         = 1'b1;
          emit_addr_nxt = q_addr;
          base_nxt      = q_base;
          slot_nxt      = '0;
          lim_nxt       = q_slot;
          unique case (q_op)
            OP_STORE: begin
              wr_en = 1'b1;
            end
            OP_STORE_EMIT: begin
              wr_en     = 1'b1;
              all_nxt   = 1'b1;
              state_nxt = B_EMIT;
            end
            OP_FLUSH: begin
              all_nxt   = 1'b0;
              state_nxt = B_EMIT;
            end
            default: begin
              wr_en = 1'b0;
            end
          endcase
        end
      end
      B_EMIT: begin
        if (issue) begin
          slot_nxt = slot_r + SW'(1);
          if (slot_r == SW'(BLOCK_LENGTH - 1)) begin
            state_nxt = B_IDLE;
          end
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    emit_addr_r <= emit_addr_nxt;
    base_r      <= base_nxt;
    slot_r      <= slot_nxt;
    lim_r       <= lim_nxt;
    all_r       <= all_nxt;
  end

  // Block store with one write and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_idx] <= q_value;
    end
    if (issue) begin
      rd_data_r <= store_mem[rd_idx];
    end
  end

  // Read stage tags that travel with the read data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else if (p1_free) begin
      p1_valid_r <= issue;
    end
    if (issue) begin
      p1_addr_r   <= emit_addr_r;
      p1_slot_r   <= slot_r;
      p1_filled_r <= all_r || (slot_r < lim_r);
      p1_last_r   <= (slot_r == SW'(BLOCK_LENGTH - 1));
    end
  end

  // Output register; slots never filled read as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= p1_valid_r;
    end
    if (p1_move) begin
      out_addr_r  <= ADDR_W'(p1_addr_r);
      out_slot_r  <= SLOT_W'(p1_slot_r);
      out_value_r <= p1_filled_r ? VAL_W'(rd_sval) : '0;
      out_last_r  <= p1_last_r;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.block_address = out_addr_r;
  assign out_chan.slot_index    = out_slot_r;
  assign out_chan.slot_value    = out_value_r;
  assign out_chan.last_of_block = out_last_r;

endmodule

`default_nettype wire
